### rtl/core/pwmrc_pkg.sv
// Shared types, constants and register map for the pulse-width remote code decoder.
// No dependencies; used by pwmrc_bit_judge and pwm_remote_code_decoder.
`default_nettype none

package pwmrc_pkg;

    // Default pulse duration field width (us counts)
    localparam int DURATION_BITS_DEF = 24;

    // Field widths
    localparam int CODE_W     = 32;
    localparam int TIME_W     = 16;
    localparam int GUARD_W    = 24;
    localparam int FRAME_W    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int PHASE_W    = 2;

    // Longest frame that fits the code word
    localparam logic [FRAME_W-1:0] MAX_FRAME = 6'd32;

    // Register reset values
    localparam logic [TIME_W-1:0]  SHORT_TIME_RST      = 16'd300;
    localparam logic [TIME_W-1:0]  LONG_TIME_RST       = 16'd900;
    localparam logic [TIME_W-1:0]  SHORT_TOLERANCE_RST = 16'd200;
    localparam logic [TIME_W-1:0]  LONG_TOLERANCE_RST  = 16'd600;
    localparam logic [GUARD_W-1:0] GUARD_TIME_RST      = 24'd7000;
    localparam logic [FRAME_W-1:0] FRAME_BITS_RST      = 6'd25;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_TIME      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_TOLERANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TOLERANCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GUARD_TIME      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BITS      = 3'd5;

    // Receiver phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE      = 2'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT_HIGH = 2'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT_LOW  = 2'd2;

    // Timing match flags for one high/low pulse pair
    typedef struct packed {
        logic hi_long;   // stored high pulse near long_time
        logic hi_short;  // stored high pulse near short_time
        logic lo_long;   // current low pulse near long_time
        logic lo_short;  // current low pulse near short_time
    } match_t;

endpackage

`default_nettype wire

### rtl/core/pwmrc_bit_judge.sv
// Tolerance windows for a high/low pulse pair: four |d - nominal| < tol checks.
// Depends on pwmrc_pkg (match_t, widths).
`default_nettype none

module pwmrc_bit_judge #(
    parameter int DURATION_BITS = pwmrc_pkg::DURATION_BITS_DEF
) (
    input  wire logic [DURATION_BITS-1:0]      high_length,
    input  wire logic [DURATION_BITS-1:0]      low_length,
    input  wire logic [pwmrc_pkg::TIME_W-1:0]  short_time,
    input  wire logic [pwmrc_pkg::TIME_W-1:0]  long_time,
    input  wire logic [pwmrc_pkg::TIME_W-1:0]  short_tolerance,
    input  wire logic [pwmrc_pkg::TIME_W-1:0]  long_tolerance,
    output pwmrc_pkg::match_t                  match
);

    // DURATION_BITS >= TIME_W, so the difference fits in DURATION_BITS
    function automatic logic near(
        input logic [DURATION_BITS-1:0]     a,
        input logic [pwmrc_pkg::TIME_W-1:0] b,
        input logic [pwmrc_pkg::TIME_W-1:0] tol
    );
        logic [DURATION_BITS-1:0] bx;
        logic [DURATION_BITS-1:0] tx;
        logic [DURATION_BITS-1:0] diff;
        bx   = DURATION_BITS'(b);
        tx   = DURATION_BITS'(tol);
        diff = (a >= bx) ? (a - bx) : (bx - a);
        return diff < tx;
    endfunction

    assign match.hi_long  = near(high_length, long_time,  long_tolerance);
    assign match.hi_short = near(high_length, short_time, short_tolerance);
    assign match.lo_long  = near(low_length,  long_time,  long_tolerance);
    assign match.lo_short = near(low_length,  short_time, short_tolerance);

endmodule

`default_nettype wire

### rtl/core/pwm_remote_code_decoder.sv
// Pulse-width remote code decoder, top level: pulse stream in, frame codes out.
// Depends on pwmrc_pkg and pwmrc_bit_judge.
`default_nettype none

// Decodes keyfob-style pulse-width frames from a stream of measured pulses.
// Each input word is one pulse: s_tuser carries the level (1 = carrier, 0 = gap)
// and s_tdata the duration in microseconds. A gap longer than guard_time closes
// a frame; if exactly frame_bits bits (capped at 32) were collected since the
// previous guard, the code is sent on m_tdata, first bit in the most significant
// used position. A long high followed by a short low is a 1, a short high
// followed by a long low is a 0 (each within its tolerance, exclusive; the 1
// pattern wins if both fit). Any mismatch, or two highs in a row, parks the
// decoder until the next guard. Bits past the frame length are accepted and
// dropped. Throughput is one pulse per clock while no code waits on m_tready:
// each pulse goes through an input register, one stage of compare logic (four
// tolerance windows and the guard compare), and a result register, from which
// a code appears on m_tvalid. A code waiting on m_tready holds every pulse
// behind it; the input register absorbs one more pulse before s_tready drops.
// Registers are written through cfg_* (always ready) and should be changed only
// while no pulse is in flight.
module pwm_remote_code_decoder #(
    parameter int DURATION_BITS = pwmrc_pkg::DURATION_BITS_DEF  // 16..32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    // pulse input
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    input  wire logic [((DURATION_BITS+7)/8)*8-1:0]  s_tdata,   // duration, zero pad
    input  wire logic                                s_tuser,   // level

    // decoded codes
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    output      logic [pwmrc_pkg::CODE_W-1:0]        m_tdata,   // code

    // register writes
    input  wire logic                                cfg_valid,
    output      logic                                cfg_ready,
    input  wire logic [pwmrc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pwmrc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CMP_W = (DURATION_BITS > pwmrc_pkg::GUARD_W) ?
                           DURATION_BITS : pwmrc_pkg::GUARD_W;

    // ---------------- configuration registers ----------------
    logic [pwmrc_pkg::TIME_W-1:0]  short_time_reg;
    logic [pwmrc_pkg::TIME_W-1:0]  long_time_reg;
    logic [pwmrc_pkg::TIME_W-1:0]  short_tol_reg;
    logic [pwmrc_pkg::TIME_W-1:0]  long_tol_reg;
    logic [pwmrc_pkg::GUARD_W-1:0] guard_time_reg;
    logic [pwmrc_pkg::FRAME_W-1:0] frame_bits_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_time_reg <= pwmrc_pkg::SHORT_TIME_RST;
            long_time_reg  <= pwmrc_pkg::LONG_TIME_RST;
            short_tol_reg  <= pwmrc_pkg::SHORT_TOLERANCE_RST;
            long_tol_reg   <= pwmrc_pkg::LONG_TOLERANCE_RST;
            guard_time_reg <= pwmrc_pkg::GUARD_TIME_RST;
            frame_bits_reg <= pwmrc_pkg::FRAME_BITS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                pwmrc_pkg::REG_SHORT_TIME:
                    short_time_reg <= cfg_data[pwmrc_pkg::TIME_W-1:0];
                pwmrc_pkg::REG_LONG_TIME:
                    long_time_reg <= cfg_data[pwmrc_pkg::TIME_W-1:0];
                pwmrc_pkg::REG_SHORT_TOLERANCE:
                    short_tol_reg <= cfg_data[pwmrc_pkg::TIME_W-1:0];
                pwmrc_pkg::REG_LONG_TOLERANCE:
                    long_tol_reg <= cfg_data[pwmrc_pkg::TIME_W-1:0];
                pwmrc_pkg::REG_GUARD_TIME:
                    guard_time_reg <= cfg_data[pwmrc_pkg::GUARD_W-1:0];
                pwmrc_pkg::REG_FRAME_BITS:
                    frame_bits_reg <= cfg_data[pwmrc_pkg::FRAME_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ---------------- input register ----------------
    logic                     in_valid_reg;
    logic                     in_level_reg;
    logic [DURATION_BITS-1:0] in_dur_reg;

    logic stage_free;  // result slot empty or being drained
    logic fire;        // pulse in the input register is processed this cycle

    assign stage_free = !m_tvalid || m_tready;
    assign fire       = in_valid_reg && stage_free;
    assign s_tready   = !in_valid_reg || stage_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_level_reg <= s_tuser;
            in_dur_reg   <= s_tdata[DURATION_BITS-1:0];
        end
    end

    // ---------------- decoder state ----------------
    logic [pwmrc_pkg::PHASE_W-1:0] phase_reg,     phase_next;
    logic [pwmrc_pkg::CODE_W-1:0]  shift_code_reg, shift_code_next;
    logic [pwmrc_pkg::FRAME_W-1:0] bits_seen_reg, bits_seen_next;
    logic [DURATION_BITS-1:0]      high_len_reg,  high_len_next;

    logic                          m_valid_reg,   m_valid_next;
    logic [pwmrc_pkg::CODE_W-1:0]  m_code_reg,    m_code_next;

    // Timing windows
    pwmrc_pkg::match_t match;

    pwmrc_bit_judge #(
        .DURATION_BITS (DURATION_BITS)
    ) u_judge (
        .high_length     (high_len_reg),
        .low_length      (in_dur_reg),
        .short_time      (short_time_reg),
        .long_time       (long_time_reg),
        .short_tolerance (short_tol_reg),
        .long_tolerance  (long_tol_reg),
        .match           (match)
    );

    logic                          is_guard;
    logic [pwmrc_pkg::FRAME_W-1:0] frame_limit;
    logic                          bit_one;
    logic                          bit_zero;

    assign is_guard    = !in_level_reg &&
                         (CMP_W'(in_dur_reg) > CMP_W'(guard_time_reg));
    assign frame_limit = (frame_bits_reg > pwmrc_pkg::MAX_FRAME) ?
                         pwmrc_pkg::MAX_FRAME : frame_bits_reg;
    assign bit_one     = match.hi_long && match.lo_short;
    assign bit_zero    = match.hi_short && match.lo_long;

    always_comb begin
        phase_next      = phase_reg;
        shift_code_next = shift_code_reg;
        bits_seen_next  = bits_seen_reg;
        high_len_next   = high_len_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_code_next     = m_code_reg;

        if (fire) begin
            if (is_guard) begin
                // End of frame, emit only on an exact bit count
                if (bits_seen_reg == frame_limit) begin
                    m_valid_next = 1'b1;
                    m_code_next  = shift_code_reg;
                end
                phase_next      = pwmrc_pkg::PH_WAIT_HIGH;
                shift_code_next = '0;
                bits_seen_next  = '0;
            end else begin
                unique case (phase_reg)
                    pwmrc_pkg::PH_WAIT_HIGH: begin
                        if (in_level_reg) begin
                            high_len_next = in_dur_reg;
                            phase_next    = pwmrc_pkg::PH_WAIT_LOW;
                        end
                    end
                    pwmrc_pkg::PH_WAIT_LOW: begin
                        if (in_level_reg) begin
                            phase_next = pwmrc_pkg::PH_IDLE;  // two highs in a row
                        end else if (bit_one || bit_zero) begin
                            if (bits_seen_reg < frame_limit) begin
                                shift_code_next = {shift_code_reg[pwmrc_pkg::CODE_W-2:0],
                                                   bit_one};
                                bits_seen_next  = bits_seen_reg + 1'b1;
                            end
                            phase_next = pwmrc_pkg::PH_WAIT_HIGH;
                        end else begin
                            phase_next = pwmrc_pkg::PH_IDLE;
                        end
                    end
                    default: ;  // idle: wait for a guard
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= pwmrc_pkg::PH_IDLE;
            shift_code_reg <= '0;
            bits_seen_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            shift_code_reg <= shift_code_next;
            bits_seen_reg  <= bits_seen_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        high_len_reg <= high_len_next;
        m_code_reg   <= m_code_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_code_reg;

    // ---------------- assertions ----------------
    a_bits_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_seen_reg <= pwmrc_pkg::MAX_FRAME)
        else $error("bit count beyond code width");

    a_emit_from_guard: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(fire && is_guard))
        else $error("code emitted without a closing guard");

    a_guard_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && is_guard) |=>
            (bits_seen_reg == '0 && shift_code_reg == '0 &&
             phase_reg == pwmrc_pkg::PH_WAIT_HIGH))
        else $error("guard did not rearm the decoder");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !fire) |=> (in_valid_reg && $stable(in_dur_reg)))
        else $error("pending pulse lost while result stalled");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !is_guard) |=>
            (bits_seen_reg == $past(bits_seen_reg) ||
             bits_seen_reg == $past(bits_seen_reg) + 1'b1))
        else $error("bit count jumped");

endmodule

`default_nettype wire
